[hdl/wegs_pkg.sv]
// Shared constants, types and functions for the wave equation grid step block.
package wegs_pkg;

    localparam int GRID_SIZE   = 256;
    localparam int COORD_W     = $clog2(GRID_SIZE);
    localparam int ADDR_W      = 2 * COORD_W;
    localparam int HEIGHT_W    = 16;
    localparam int WORD_W      = 2 * HEIGHT_W;
    localparam int VEL_W       = 15;
    localparam int DECAY_W     = 16;
    localparam int CFG_W       = 16;
    localparam int VEL_MAX     = 16384;
    localparam int DECAY_MAX   = 32768;
    localparam int DROP_RADIUS = 4;
    localparam int DROP_SPAN   = 2 * DROP_RADIUS;
    localparam int DROP_G_W    = 11;

    // datapath widths: laplacian and leapfrog sum fit in 19 signed bits
    localparam int LAP_W   = 19;
    localparam int VAL_W   = 19;
    localparam int MUL_A_W = 19;
    localparam int MUL_B_W = 16;
    localparam int PROD_W  = MUL_A_W + MUL_B_W + 1;
    localparam int RND_W   = PROD_W - 15;

    localparam logic [1:0] OP_STEP = 2'd0;
    localparam logic [1:0] OP_DROP = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    localparam logic REG_VELOCITY = 1'b0;
    localparam logic REG_DECAY    = 1'b1;

    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr_a;
        logic [ADDR_W-1:0] rd_addr_b;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [WORD_W-1:0] wr_data;
    } mem_req_t;

    function automatic logic signed [HEIGHT_W-1:0] sat16(input logic signed [RND_W-1:0] x);
        logic signed [HEIGHT_W-1:0] r;
        if (x > RND_W'(32767)) begin
            r = 16'sh7fff;
        end else if (x < -RND_W'(32768)) begin
            r = 16'sh8000;
        end else begin
            r = x[HEIGHT_W-1:0];
        end
        return r;
    endfunction

    // Gaussian bump quadrant, indexed by |dy| then |dx|
    function automatic logic [DROP_G_W-1:0] drop_gain(input logic [2:0] ady,
                                                      input logic [2:0] adx);
        logic [DROP_G_W-1:0] g;
        case ({ady, adx})
            6'o00: g = 11'd1024;
            6'o01: g = 11'd797;
            6'o02: g = 11'd377;
            6'o03: g = 11'd108;
            6'o04: g = 11'd19;
            6'o10: g = 11'd797;
            6'o11: g = 11'd621;
            6'o12: g = 11'd293;
            6'o13: g = 11'd84;
            6'o14: g = 11'd15;
            6'o20: g = 11'd377;
            6'o21: g = 11'd293;
            6'o22: g = 11'd139;
            6'o23: g = 11'd40;
            6'o24: g = 11'd7;
            6'o30: g = 11'd108;
            6'o31: g = 11'd84;
            6'o32: g = 11'd40;
            6'o33: g = 11'd11;
            6'o34: g = 11'd2;
            6'o40: g = 11'd19;
            6'o41: g = 11'd15;
            6'o42: g = 11'd7;
            6'o43: g = 11'd2;
            default: g = '0;
        endcase
        return g;
    endfunction

endpackage

[hdl/wegs_ram.sv]
// Dual read port, single write port RAM with registered read data.
module wegs_ram #(
    parameter int DATA_W = 32,
    parameter int ADDR_W = 16
) (
    input  logic              aclk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr_a,
    input  logic [ADDR_W-1:0] rd_addr_b,
    output logic [DATA_W-1:0] rd_data_a,
    output logic [DATA_W-1:0] rd_data_b,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data
);

    logic [DATA_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

[hdl/wegs_mul.sv]
// Shared signed-by-unsigned multiplier with Q15 round half away from zero.
module wegs_mul
    import wegs_pkg::*;
(
    input  logic                      aclk,
    input  logic signed [MUL_A_W-1:0] mul_a,
    input  logic        [MUL_B_W-1:0] mul_b,
    output logic signed [RND_W-1:0]   mul_rnd
);

    logic signed [MUL_B_W:0]   b_s;
    logic signed [PROD_W-1:0]  prod_next;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [PROD_W-1:0]  bias;
    logic signed [PROD_W-1:0]  biased;

    assign b_s       = $signed({1'b0, mul_b});
    assign prod_next = mul_a * b_s;

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

    // negative values round with 2^14-1 so the arithmetic shift lands away from zero
    assign bias    = prod_reg[PROD_W-1] ? PROD_W'(16383) : PROD_W'(16384);
    assign biased  = prod_reg + bias;
    assign mul_rnd = biased[PROD_W-1:15];

endmodule

[hdl/wegs_ctrl.sv]
// Sequencer for grid clear, leapfrog step, droplet add and cell read.
module wegs_ctrl
    import wegs_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [1:0]                 s_opcode,
    input  logic [7:0]                 s_col,
    input  logic [7:0]                 s_row,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [HEIGHT_W-1:0]        m_value,
    output logic                       m_status,
    input  logic [VEL_W-1:0]           vel_gain,
    input  logic [DECAY_W-1:0]         decay_gain,
    output mem_req_t                   mem_req,
    input  logic [WORD_W-1:0]          mem_rd_data_a,
    input  logic [WORD_W-1:0]          mem_rd_data_b,
    output logic signed [MUL_A_W-1:0]  mul_a,
    output logic        [MUL_B_W-1:0]  mul_b,
    input  logic signed [RND_W-1:0]    mul_rnd
);

    localparam logic [3:0] ST_CLEAR  = 4'd0;
    localparam logic [3:0] ST_IDLE   = 4'd1;
    localparam logic [3:0] ST_S_RD0  = 4'd2;
    localparam logic [3:0] ST_S_RD1  = 4'd3;
    localparam logic [3:0] ST_S_RD2  = 4'd4;
    localparam logic [3:0] ST_S_LAP  = 4'd5;
    localparam logic [3:0] ST_S_MUL1 = 4'd6;
    localparam logic [3:0] ST_S_ACC  = 4'd7;
    localparam logic [3:0] ST_S_MUL2 = 4'd8;
    localparam logic [3:0] ST_S_WR   = 4'd9;
    localparam logic [3:0] ST_D_RD   = 4'd10;
    localparam logic [3:0] ST_D_WR   = 4'd11;
    localparam logic [3:0] ST_R_RD   = 4'd12;
    localparam logic [3:0] ST_R_DAT  = 4'd13;
    localparam logic [3:0] ST_DONE   = 4'd14;

    localparam logic [COORD_W-1:0] LAST = COORD_W'(GRID_SIZE - 1);

    logic [3:0]                  state_reg;
    logic [COORD_W-1:0]          x_reg, y_reg;
    logic                        plane_reg;
    logic signed [HEIGHT_W-1:0]  c_reg, p_reg, l_reg, r_reg, u_reg;
    logic signed [LAP_W-1:0]     lap_reg;
    logic signed [VAL_W-1:0]     val_reg;
    logic [COORD_W-1:0]          cx_reg, cy_reg;
    logic [3:0]                  dx_reg, dy_reg;
    logic [HEIGHT_W-1:0]         res_value_reg;
    logic                        res_status_reg;
    logic                        m_valid_reg;
    logic [HEIGHT_W-1:0]         m_value_reg;
    logic                        m_status_reg;

    logic [COORD_W-1:0]          xm, xp, ym, yp;
    logic                        last_cell;
    logic [COORD_W-1:0]          x_adv, y_adv;
    logic signed [HEIGHT_W-1:0]  d_cur;
    logic signed [LAP_W-1:0]     lap_next;
    logic signed [VAL_W-1:0]     val_next;
    logic signed [HEIGHT_W-1:0]  new_h;
    logic [WORD_W-1:0]           step_word;
    logic [COORD_W-1:0]          drop_x, drop_y;
    logic [3:0]                  adx, ady;
    logic signed [DROP_G_W:0]    g_s;
    logic signed [HEIGHT_W-1:0]  drop_h0, drop_h1;
    logic                        drop_ok, read_ok;
    logic                        accept;
    logic                        result_load;

    function automatic logic signed [HEIGHT_W-1:0] half(input logic [WORD_W-1:0] w,
                                                        input logic z);
        return z ? w[WORD_W-1:HEIGHT_W] : w[HEIGHT_W-1:0];
    endfunction

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_value  = m_value_reg;
    assign m_status = m_status_reg;

    // finished command moves into the output register once it is free
    assign result_load = (state_reg == ST_DONE) && (!m_valid_reg || m_tready);

    // toroidal neighbours
    assign xm = (x_reg == '0)  ? LAST : x_reg - 1'b1;
    assign xp = (x_reg == LAST) ? '0  : x_reg + 1'b1;
    assign ym = (y_reg == '0)  ? LAST : y_reg - 1'b1;
    assign yp = (y_reg == LAST) ? '0  : y_reg + 1'b1;

    assign last_cell = (x_reg == LAST) && (y_reg == LAST);
    assign x_adv     = (x_reg == LAST) ? '0 : x_reg + 1'b1;
    assign y_adv     = (x_reg == LAST) ? y_reg + 1'b1 : y_reg;

    assign d_cur    = half(mem_rd_data_a, plane_reg);
    assign lap_next = LAP_W'(l_reg) + LAP_W'(r_reg) + LAP_W'(u_reg) + LAP_W'(d_cur)
                    - (LAP_W'(c_reg) <<< 2);
    assign val_next = (VAL_W'(c_reg) <<< 1) - VAL_W'(p_reg) + VAL_W'(mul_rnd);
    assign new_h    = sat16(mul_rnd);
    assign step_word = plane_reg ? {c_reg, new_h} : {new_h, c_reg};

    assign mul_a = (state_reg == ST_S_MUL1) ? MUL_A_W'(lap_reg) : MUL_A_W'(val_reg);
    assign mul_b = (state_reg == ST_S_MUL1) ? MUL_B_W'(vel_gain) : decay_gain;

    // droplet walker: counters 0..8 give offsets -4..4 around the centre
    assign drop_x  = cx_reg + COORD_W'(dx_reg) - COORD_W'(DROP_RADIUS);
    assign drop_y  = cy_reg + COORD_W'(dy_reg) - COORD_W'(DROP_RADIUS);
    assign adx     = (dx_reg < 4'(DROP_RADIUS)) ? 4'(DROP_RADIUS) - dx_reg
                                                : dx_reg - 4'(DROP_RADIUS);
    assign ady     = (dy_reg < 4'(DROP_RADIUS)) ? 4'(DROP_RADIUS) - dy_reg
                                                : dy_reg - 4'(DROP_RADIUS);
    assign g_s     = $signed({1'b0, drop_gain(ady[2:0], adx[2:0])});
    assign drop_h0 = sat16(RND_W'($signed(mem_rd_data_a[HEIGHT_W-1:0])) + RND_W'(g_s));
    assign drop_h1 = sat16(RND_W'($signed(mem_rd_data_a[WORD_W-1:HEIGHT_W])) + RND_W'(g_s));

    assign drop_ok = (s_col >= 8'(DROP_RADIUS)) && (s_row >= 8'(DROP_RADIUS))
                  && (32'(s_col) + DROP_RADIUS <= GRID_SIZE - 1)
                  && (32'(s_row) + DROP_RADIUS <= GRID_SIZE - 1);
    assign read_ok = (32'(s_col) < GRID_SIZE) && (32'(s_row) < GRID_SIZE);

    always_comb begin
        mem_req = '0;
        case (state_reg)
            ST_CLEAR: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = {y_reg, x_reg};
            end
            ST_S_RD0: begin
                mem_req.rd_en     = 1'b1;
                mem_req.rd_addr_a = {y_reg, x_reg};
                mem_req.rd_addr_b = {y_reg, xm};
            end
            ST_S_RD1: begin
                mem_req.rd_en     = 1'b1;
                mem_req.rd_addr_a = {y_reg, xp};
                mem_req.rd_addr_b = {ym, x_reg};
            end
            ST_S_RD2: begin
                mem_req.rd_en     = 1'b1;
                mem_req.rd_addr_a = {yp, x_reg};
                mem_req.rd_addr_b = {yp, x_reg};
            end
            ST_S_WR: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = {y_reg, x_reg};
                mem_req.wr_data = step_word;
            end
            ST_D_RD: begin
                mem_req.rd_en     = 1'b1;
                mem_req.rd_addr_a = {drop_y, drop_x};
                mem_req.rd_addr_b = {drop_y, drop_x};
            end
            ST_D_WR: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = {drop_y, drop_x};
                mem_req.wr_data = {drop_h1, drop_h0};
            end
            ST_R_RD: begin
                mem_req.rd_en     = 1'b1;
                mem_req.rd_addr_a = {y_reg, x_reg};
                mem_req.rd_addr_b = {y_reg, x_reg};
            end
            default: begin
                mem_req = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            x_reg       <= '0;
            y_reg       <= '0;
            plane_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (result_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR: begin
                    x_reg <= x_adv;
                    y_reg <= y_adv;
                    if (last_cell) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (accept) begin
                        res_value_reg  <= '0;
                        res_status_reg <= (s_opcode == OP_DROP) && !drop_ok;
                        case (s_opcode)
                            OP_STEP: begin
                                x_reg     <= '0;
                                y_reg     <= '0;
                                state_reg <= ST_S_RD0;
                            end
                            OP_DROP: begin
                                cx_reg <= COORD_W'(s_col);
                                cy_reg <= COORD_W'(s_row);
                                dx_reg <= '0;
                                dy_reg <= '0;
                                state_reg <= drop_ok ? ST_D_RD : ST_DONE;
                            end
                            OP_READ: begin
                                x_reg     <= COORD_W'(s_col);
                                y_reg     <= COORD_W'(s_row);
                                state_reg <= read_ok ? ST_R_RD : ST_DONE;
                            end
                            default: begin
                                state_reg <= ST_DONE;
                            end
                        endcase
                    end
                end
                ST_S_RD0: begin
                    state_reg <= ST_S_RD1;
                end
                ST_S_RD1: begin
                    c_reg     <= half(mem_rd_data_a, plane_reg);
                    p_reg     <= half(mem_rd_data_a, !plane_reg);
                    l_reg     <= half(mem_rd_data_b, plane_reg);
                    state_reg <= ST_S_RD2;
                end
                ST_S_RD2: begin
                    r_reg     <= half(mem_rd_data_a, plane_reg);
                    u_reg     <= half(mem_rd_data_b, plane_reg);
                    state_reg <= ST_S_LAP;
                end
                ST_S_LAP: begin
                    lap_reg   <= lap_next;
                    state_reg <= ST_S_MUL1;
                end
                ST_S_MUL1: begin
                    state_reg <= ST_S_ACC;
                end
                ST_S_ACC: begin
                    val_reg   <= val_next;
                    state_reg <= ST_S_MUL2;
                end
                ST_S_MUL2: begin
                    state_reg <= ST_S_WR;
                end
                ST_S_WR: begin
                    x_reg <= x_adv;
                    y_reg <= y_adv;
                    if (last_cell) begin
                        plane_reg <= !plane_reg;
                        state_reg <= ST_DONE;
                    end else begin
                        state_reg <= ST_S_RD0;
                    end
                end
                ST_D_RD: begin
                    state_reg <= ST_D_WR;
                end
                ST_D_WR: begin
                    if (dx_reg == 4'(DROP_SPAN)) begin
                        dx_reg <= '0;
                        dy_reg <= dy_reg + 1'b1;
                        state_reg <= (dy_reg == 4'(DROP_SPAN)) ? ST_DONE : ST_D_RD;
                    end else begin
                        dx_reg    <= dx_reg + 1'b1;
                        state_reg <= ST_D_RD;
                    end
                end
                ST_R_RD: begin
                    state_reg <= ST_R_DAT;
                end
                ST_R_DAT: begin
                    res_value_reg <= half(mem_rd_data_a, plane_reg);
                    state_reg     <= ST_DONE;
                end
                ST_DONE: begin
                    if (result_load) begin
                        m_value_reg  <= res_value_reg;
                        m_status_reg <= res_status_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg != ST_IDLE))
        else $error("accepted command did not start");

    a_plane_flip_at_step_end: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && (plane_reg != $past(plane_reg))) |-> ($past(state_reg) == ST_S_WR))
        else $error("plane select changed outside the end of a step");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && m_valid_reg && !$past(m_valid_reg))
            |-> ($past(state_reg) == ST_DONE))
        else $error("result appeared without a finished command");

    a_no_rd_wr_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mem_req.rd_en && mem_req.wr_en))
        else $error("grid read and write in the same cycle");

endmodule

[hdl/wave_equation_grid_step.sv]
// Top level: 2-D leapfrog wave equation grid with config registers.
//
// Commands arrive on the s_axis channel (opcode in tuser, col/row in tdata);
// each command gives exactly one result on m_axis (cell value in tdata, droplet-reject
// status in tuser). Gains must be set on the cfg write port only while the block is
// idle (the block does not enforce it); index 0 is velocity gain, index 1 decay gain.
// Work per command:
//   step    : one cell at a time through the shared multiplier (three grid
//             reads, laplacian, two multiplies)
//   droplet : read-modify-write of each bump cell; reject: no grid access
//   read    : one registered grid read
// s_axis_tready is high only while no command is in progress.
// After reset the grid is cleared one cell per cycle; no command is taken
// during the sweep, but cfg writes are. If m_axis_tready is low, the result
// is held and one more command may be taken; the next result then waits
// until the held one moves.
module wave_equation_grid_step
    import wegs_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [15:0]         s_axis_tdata,   // [7:0] col, [15:8] row
    input  logic [1:0]          s_axis_tuser,   // [1:0] opcode
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [15:0]         m_axis_tdata,   // [15:0] cell_value
    output logic [0:0]          m_axis_tuser,   // [0] status
    input  logic                cfg_wr_en,
    input  logic [0:0]          cfg_addr,
    input  logic [CFG_W-1:0]    cfg_wr_data
);

    logic [VEL_W-1:0]          vel_reg;
    logic [DECAY_W-1:0]        decay_reg;
    logic [VEL_W-1:0]          vel_eff;
    logic [DECAY_W-1:0]        decay_eff;
    mem_req_t                  mem_req;
    logic [WORD_W-1:0]         rd_data_a, rd_data_b;
    logic signed [MUL_A_W-1:0] mul_a;
    logic        [MUL_B_W-1:0] mul_b;
    logic signed [RND_W-1:0]   mul_rnd;
    logic                      m_status;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vel_reg   <= VEL_W'(VEL_MAX);
            decay_reg <= DECAY_W'(31457);
        end else if (cfg_wr_en) begin
            case (cfg_addr[0])
                REG_VELOCITY: vel_reg   <= cfg_wr_data[VEL_W-1:0];
                REG_DECAY:    decay_reg <= cfg_wr_data[DECAY_W-1:0];
                default:      vel_reg   <= vel_reg;
            endcase
        end
    end

    // out-of-range gains act as their maximum
    assign vel_eff   = (32'(vel_reg) > VEL_MAX) ? VEL_W'(VEL_MAX) : vel_reg;
    assign decay_eff = (32'(decay_reg) > DECAY_MAX) ? DECAY_W'(DECAY_MAX) : decay_reg;

    wegs_ram #(
        .DATA_W (WORD_W),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .aclk      (aclk),
        .rd_en     (mem_req.rd_en),
        .rd_addr_a (mem_req.rd_addr_a),
        .rd_addr_b (mem_req.rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b),
        .wr_en     (mem_req.wr_en),
        .wr_addr   (mem_req.wr_addr),
        .wr_data   (mem_req.wr_data)
    );

    wegs_mul u_mul (
        .aclk    (aclk),
        .mul_a   (mul_a),
        .mul_b   (mul_b),
        .mul_rnd (mul_rnd)
    );

    wegs_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_axis_tvalid),
        .s_tready      (s_axis_tready),
        .s_opcode      (s_axis_tuser),
        .s_col         (s_axis_tdata[7:0]),
        .s_row         (s_axis_tdata[15:8]),
        .m_tvalid      (m_axis_tvalid),
        .m_tready      (m_axis_tready),
        .m_value       (m_axis_tdata),
        .m_status      (m_status),
        .vel_gain      (vel_eff),
        .decay_gain    (decay_eff),
        .mem_req       (mem_req),
        .mem_rd_data_a (rd_data_a),
        .mem_rd_data_b (rd_data_b),
        .mul_a         (mul_a),
        .mul_b         (mul_b),
        .mul_rnd       (mul_rnd)
    );

    assign m_axis_tuser = m_status;

endmodule

[test/wave_grid_checker.sv]
// Checker for the wave grid block: tracks both height planes, predicts each reply and compares.
`timescale 1ns / 1ps

module wave_grid_checker
    import wegs_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_axis_tvalid,
    input  logic               s_axis_tready,
    input  logic [15:0]        s_axis_tdata,   // [7:0] col, [15:8] row
    input  logic [1:0]         s_axis_tuser,   // [1:0] opcode
    input  logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    input  logic [15:0]        m_axis_tdata,   // [15:0] cell_value
    input  logic [0:0]         m_axis_tuser,   // [0] status
    input  logic               cfg_wr_en,
    input  logic [0:0]         cfg_addr,
    input  logic [CFG_W-1:0]   cfg_wr_data,
    output int                 pending_count,
    output int                 mismatch_count
);

    localparam int CELLS       = GRID_SIZE * GRID_SIZE;
    localparam int VEL_RESET   = 16384;
    localparam int DECAY_RESET = 31457;
    localparam int EDGE_LO     = DROP_RADIUS;
    localparam int EDGE_HI     = GRID_SIZE - 1 - DROP_RADIUS;

    typedef struct packed {
        logic [HEIGHT_W-1:0] cell_value;
        logic                status;
    } grid_reply_t;

    logic signed [HEIGHT_W-1:0] heights [2][CELLS];
    int                         live_plane;
    int                         velocity_setting;
    int                         decay_setting;
    grid_reply_t                expected_replies [$];

    // >> 15, rounding half away from zero
    function automatic longint round_q15(input longint x);
        longint mag;
        mag = (x < 0) ? -x : x;
        mag = (mag + 16384) >>> 15;
        return (x < 0) ? -mag : mag;
    endfunction

    function automatic logic signed [HEIGHT_W-1:0] clamp_height(input longint x);
        logic signed [HEIGHT_W-1:0] r;
        if (x > 32767) begin
            r = 16'sh7fff;
        end else if (x < -32768) begin
            r = 16'sh8000;
        end else begin
            r = HEIGHT_W'(x);
        end
        return r;
    endfunction

    // Gaussian bump sample 1024 * exp(-(dx^2 + dy^2) / 4), rounded
    function automatic int bump_height(input int dx, input int dy);
        return $rtoi(1024.0 * $exp(-(dx * dx + dy * dy) / 4.0) + 0.5);
    endfunction

    // one leapfrog step over the torus; new plane overwrites the previous one
    function automatic void advance_grid();
        int     cur, prv, x, y, xm, xp, ym, yp, k;
        longint v, d, c, p, lap, val;
        cur = live_plane;
        prv = cur ^ 1;
        v = (velocity_setting > VEL_MAX) ? VEL_MAX : velocity_setting;
        d = (decay_setting > DECAY_MAX) ? DECAY_MAX : decay_setting;
        for (y = 0; y < GRID_SIZE; y++) begin
            ym = (y == 0) ? GRID_SIZE - 1 : y - 1;
            yp = (y == GRID_SIZE - 1) ? 0 : y + 1;
            for (x = 0; x < GRID_SIZE; x++) begin
                xm = (x == 0) ? GRID_SIZE - 1 : x - 1;
                xp = (x == GRID_SIZE - 1) ? 0 : x + 1;
                k = y * GRID_SIZE + x;
                c = heights[cur][k];
                p = heights[prv][k];
                lap = heights[cur][y * GRID_SIZE + xm];
                lap += heights[cur][y * GRID_SIZE + xp];
                lap += heights[cur][ym * GRID_SIZE + x];
                lap += heights[cur][yp * GRID_SIZE + x];
                lap -= 4 * c;
                val = 2 * c - p + round_q15(v * lap);
                heights[prv][k] = clamp_height(round_q15(val * d));
            end
        end
        live_plane = prv;
    endfunction

    // returns the reject flag; bump goes into both planes
    function automatic logic place_droplet(input int cx, input int cy);
        int dx, dy, z, k;
        if (cx < EDGE_LO || cy < EDGE_LO || cx > EDGE_HI || cy > EDGE_HI) begin
            return 1'b1;
        end
        for (dy = -DROP_RADIUS; dy <= DROP_RADIUS; dy++) begin
            for (dx = -DROP_RADIUS; dx <= DROP_RADIUS; dx++) begin
                k = (cy + dy) * GRID_SIZE + cx + dx;
                for (z = 0; z < 2; z++) begin
                    heights[z][k] = clamp_height(longint'(heights[z][k]) + bump_height(dx, dy));
                end
            end
        end
        return 1'b0;
    endfunction

    function automatic grid_reply_t predict_command(input logic [1:0] op, input int col,
                                                    input int row);
        grid_reply_t reply;
        reply.cell_value = '0;
        reply.status     = 1'b0;
        case (op)
            OP_STEP: begin
                advance_grid();
            end
            OP_DROP: begin
                reply.status = place_droplet(col, row);
            end
            OP_READ: begin
                if (col < GRID_SIZE && row < GRID_SIZE) begin
                    reply.cell_value = heights[live_plane][row * GRID_SIZE + col];
                end
            end
            default: begin
            end
        endcase
        return reply;
    endfunction

    always @(posedge aclk) begin : track
        int          i;
        grid_reply_t want;
        if (!aresetn) begin
            for (i = 0; i < CELLS; i++) begin
                heights[0][i] = '0;
                heights[1][i] = '0;
            end
            live_plane       = 0;
            velocity_setting = VEL_RESET;
            decay_setting    = DECAY_RESET;
            mismatch_count   = 0;
            expected_replies.delete();
            pending_count <= 0;
        end else begin
            // older replies leave before a new command is predicted
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_replies.size() == 0) begin
                    $error("unexpected transfer: cell_value %0d, status %0d",
                           $signed(m_axis_tdata), m_axis_tuser[0]);
                    mismatch_count++;
                end else begin
                    want = expected_replies.pop_front();
                    if (m_axis_tdata !== want.cell_value) begin
                        $error("cell_value: expected %0d, actual %0d",
                               $signed(want.cell_value), $signed(m_axis_tdata));
                        mismatch_count++;
                    end
                    if (m_axis_tuser[0] !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, m_axis_tuser[0]);
                        mismatch_count++;
                    end
                end
            end
            if (cfg_wr_en) begin
                if (cfg_addr == REG_VELOCITY) begin
                    velocity_setting = int'(cfg_wr_data[VEL_W-1:0]);
                end else if (cfg_addr == REG_DECAY) begin
                    decay_setting = int'(cfg_wr_data[DECAY_W-1:0]);
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                expected_replies.push_back(predict_command(s_axis_tuser, s_axis_tdata[7:0],
                                                           s_axis_tdata[15:8]));
            end
            pending_count <= expected_replies.size();
        end
    end

endmodule

[test/tb_top.sv]
// Testbench top for the wave grid block: clock, reset, command stimulus, stalls and verdict.
`timescale 1ns / 1ps

module tb_top;
    import wegs_pkg::*;

    localparam int         CLK_HALF       = 6;
    localparam int         RESET_CYCLES   = 10;
    localparam int         STEP_CYCLES    = 8 * GRID_SIZE * GRID_SIZE + 2;
    localparam int         WATCHDOG_LIMIT = 3 * (STEP_CYCLES + 12);
    localparam int         SETTLE_CYCLES  = 16;
    localparam int         PILEUP_DROPS   = 34;
    localparam logic [1:0] OP_UNUSED      = 2'd3;

    logic             aclk          = 1'b0;
    logic             aresetn       = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [15:0]      s_axis_tdata  = '0;   // [7:0] col, [15:8] row
    logic [1:0]       s_axis_tuser  = '0;   // [1:0] opcode
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b1;
    logic [15:0]      m_axis_tdata;         // [15:0] cell_value
    logic [0:0]       m_axis_tuser;         // [0] status
    logic             cfg_wr_en     = 1'b0;
    logic [0:0]       cfg_addr      = '0;
    logic [CFG_W-1:0] cfg_wr_data   = '0;

    int   pending_count;
    int   mismatch_count;
    logic calm_tail   = 1'b0;
    int   stall_left  = 0;
    int   quiet_cycles = 0;
    int   n_steps     = 0;
    int   n_drops     = 0;
    int   n_reads     = 0;
    int   n_unused    = 0;

    always #(CLK_HALF) aclk = ~aclk;

    wave_equation_grid_step u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wr_data   (cfg_wr_data)
    );

    wave_grid_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tuser   (m_axis_tuser),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_addr       (cfg_addr),
        .cfg_wr_data    (cfg_wr_data),
        .pending_count  (pending_count),
        .mismatch_count (mismatch_count)
    );

    // result side backpressure in bursts of random length
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b1;
            stall_left    <= 0;
        end else if (stall_left != 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (!calm_tail && $urandom_range(0, 7) == 0) begin
            stall_left    <= $urandom_range(1, 6) - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // a step is the longest silent stretch; the limit covers it several times
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $error("no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // entered and left at a rising edge; valid stays up for back-to-back commands
    task automatic send_command(input logic [1:0] op, input logic [7:0] col,
                                input logic [7:0] row);
        if (!calm_tail && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {row, col};
        case (op)
            OP_STEP: n_steps++;
            OP_DROP: n_drops++;
            OP_READ: n_reads++;
            default: n_unused++;
        endcase
        do @(posedge aclk); while (!s_axis_tready);
    endtask

    // pending_count is registered, so look from the edge after the last transfer
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
    endtask

    task automatic set_gains(input logic [CFG_W-1:0] velocity, input logic [CFG_W-1:0] decay);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= REG_VELOCITY;
        cfg_wr_data <= velocity;
        @(posedge aclk);
        cfg_addr    <= REG_DECAY;
        cfg_wr_data <= decay;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // bump runs with nearby probes, scattered reads, noise and edge rejects
    task automatic mixed_traffic(input int n_items);
        int         sent;
        int         kind;
        logic [7:0] cx, cy;
        logic [7:0] ex, ey;
        logic [1:0] op;
        sent = 0;
        cx = 8'($urandom_range(DROP_RADIUS, GRID_SIZE - 1 - DROP_RADIUS));
        cy = 8'($urandom_range(DROP_RADIUS, GRID_SIZE - 1 - DROP_RADIUS));
        while (sent < n_items) begin
            kind = $urandom_range(0, 9);
            if (kind < 4) begin
                cx = 8'($urandom_range(DROP_RADIUS, GRID_SIZE - 1 - DROP_RADIUS));
                cy = 8'($urandom_range(DROP_RADIUS, GRID_SIZE - 1 - DROP_RADIUS));
                repeat ($urandom_range(1, 6)) begin
                    send_command(OP_DROP, cx, cy);
                    sent++;
                end
                repeat ($urandom_range(1, 3)) begin
                    send_command(OP_READ, cx + 8'($urandom_range(0, 10)) - 8'd5,
                                 cy + 8'($urandom_range(0, 10)) - 8'd5);
                    sent++;
                end
            end else if (kind < 7) begin
                if ($urandom_range(0, 1) == 1) begin
                    send_command(OP_READ, cx + 8'($urandom_range(0, 10)) - 8'd5,
                                 cy + 8'($urandom_range(0, 10)) - 8'd5);
                end else begin
                    send_command(OP_READ, 8'($urandom), 8'($urandom));
                end
                sent++;
            end else if (kind < 9) begin
                case ($urandom_range(0, 2))
                    0:       op = OP_DROP;
                    1:       op = OP_READ;
                    default: op = OP_UNUSED;
                endcase
                send_command(op, 8'($urandom), 8'($urandom));
                sent++;
            end else begin
                // centre within DROP_RADIUS of an edge on one axis
                ex = ($urandom_range(0, 1) == 1) ? 8'($urandom_range(0, DROP_RADIUS - 1))
                     : 8'($urandom_range(GRID_SIZE - DROP_RADIUS, GRID_SIZE - 1));
                ey = 8'($urandom);
                if ($urandom_range(0, 1) == 1) begin
                    send_command(OP_DROP, ex, ey);
                end else begin
                    send_command(OP_DROP, ey, ex);
                end
                sent++;
            end
        end
    endtask

    initial begin : stimulus
        logic [7:0] hot_x, hot_y;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: empty grid, rejects at every edge, corner bumps, one step at reset gains
        send_command(OP_READ, 8'd0, 8'd0);
        send_command(OP_READ, 8'd255, 8'd255);
        send_command(OP_UNUSED, 8'd255, 8'd0);
        send_command(OP_DROP, 8'd3, 8'd128);
        send_command(OP_DROP, 8'd128, 8'd3);
        send_command(OP_DROP, 8'd252, 8'd128);
        send_command(OP_DROP, 8'd128, 8'd252);
        send_command(OP_DROP, 8'd0, 8'd255);
        send_command(OP_DROP, 8'd4, 8'd4);
        send_command(OP_DROP, 8'd251, 8'd251);
        send_command(OP_DROP, 8'd4, 8'd251);
        send_command(OP_DROP, 8'd251, 8'd4);
        send_command(OP_DROP, 8'd128, 8'd128);
        send_command(OP_READ, 8'd128, 8'd128);
        send_command(OP_READ, 8'd132, 8'd128);
        send_command(OP_READ, 8'd4, 8'd4);
        send_command(OP_STEP, 8'd255, 8'd255);
        send_command(OP_READ, 8'd128, 8'd128);
        send_command(OP_READ, 8'd0, 8'd0);
        send_command(OP_READ, 8'd255, 8'd255);
        send_command(OP_READ, 8'd8, 8'd4);
        send_command(OP_READ, 8'd124, 8'd124);
        send_command(OP_UNUSED, 8'd0, 8'd255);
        drain_results();

        // both gains over range, so they clamp to their maxima
        set_gains(16'hFFFF, 16'hFFFF);
        hot_x = 8'($urandom_range(DROP_RADIUS, GRID_SIZE - 1 - DROP_RADIUS));
        hot_y = 8'($urandom_range(DROP_RADIUS, GRID_SIZE - 1 - DROP_RADIUS));
        // pile bumps on one centre until the crest saturates
        repeat (PILEUP_DROPS) send_command(OP_DROP, hot_x, hot_y);
        send_command(OP_READ, hot_x, hot_y);
        drain_results();
        mixed_traffic(20);
        send_command(OP_STEP, 8'($urandom), 8'($urandom));
        send_command(OP_READ, hot_x, hot_y);
        send_command(OP_READ, hot_x + 8'd1, hot_y);
        send_command(OP_READ, hot_x, hot_y - 8'd5);
        send_command(OP_READ, hot_x - 8'd6, hot_y + 8'd6);
        drain_results();

        set_gains(16'h0000, 16'h0000);
        mixed_traffic(25);
        calm_tail <= 1'b1;
        mixed_traffic(15);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("tb_top: %0d commands: %0d steps, %0d droplets, %0d reads, %0d unused opcode",
                 n_steps + n_drops + n_reads + n_unused, n_steps, n_drops, n_reads, n_unused);
        $display("tb_top: steps at reset and clamped gains, edge rejects, saturated crest");
        if (mismatch_count == 0 && pending_count == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
